[src/msort_pkg.sv]
// shared types and constants for the block merge sorter
// no dependencies; imported by msort_merge, merge_sorter_top and the testbench
`default_nettype none

package msort_pkg;

   localparam int DATA_W       = 32;
   localparam int MAX_CAPACITY = 64;
   localparam int DEF_CAPACITY = 64;
   // indices must hold run bounds up to twice the capacity
   localparam int IDX_W        = $clog2(MAX_CAPACITY) + 1;

   typedef logic [IDX_W-1:0] idx_type;

   // read/write positions of the run pair being merged
   typedef struct packed {
      idx_type i;
      idx_type j;
      idx_type k;
      idx_type a_end;
      idx_type b_end;
   } merge_pos_type;

   // outcome of one merge step
   typedef struct packed {
      logic    take_a;
      logic    run_done;
      idx_type i_nxt;
      idx_type j_nxt;
      idx_type k_nxt;
   } merge_step_type;

endpackage

`default_nettype wire

[src/merge_sorter_top.sv]
// block merge sorter: load, bottom-up merge passes between two rams, output
// usage:
//   requests arrive on req_ (valid/ready); req_last_in closes a block. Each
//   accepted request up to CAPACITY is written to ram0; later ones are
//   dropped and every result of that block carries rsp_overflow.
//   after the closing request the block sorts ascending (signed) in ceil(log2 n)
//   merge passes, ping-ponging between the two rams (one element per cycle
//   through the compare and ram read loop, after a setup state per run pair).
//   results then leave on rsp_ (valid/ready) after a setup state, one per
//   cycle while rsp_ready is high, the final one with rsp_last_out.
//   req_ready is low from the closing request until the last result of the
//   block has entered the output register. A stall on rsp_ready holds the
//   output register and pauses the ram read stream without losing data.
//   reset (synchronous) empties the block and the output register; ram
//   contents are not cleared and need no clearing pass.
// depends on msort_pkg, msort_ram, msort_merge
`default_nettype none

module merge_sorter_top #(
   parameter int CAPACITY = msort_pkg::DEF_CAPACITY
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [msort_pkg::DATA_W-1:0] req_value,
   input  wire logic                                req_last_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [msort_pkg::DATA_W-1:0]      rsp_sorted_value,
   output logic                                     rsp_last_out,
   output logic                                     rsp_overflow
);

   import msort_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PAIR,
      ST_MERGE,
      ST_OUT_START,
      ST_OUT
   } state_type;

   state_type     state_ff, state_in;
   idx_type       cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   idx_type       width_ff, width_in;
   idx_type       lo_ff, lo_in;
   logic          sel_ff, sel_in;
   merge_pos_type pos_ff, pos_in;
   idx_type       out_idx_ff, out_idx_in;
   logic          out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic          out_last_ff, out_last_in;
   logic          out_ovf_ff, out_ovf_in;

   logic          req_fire;
   logic          load_wr;
   idx_type       n_close;
   idx_type       cap_idx;
   idx_type       width2;
   idx_type       lo_step;
   idx_type       sum_a;
   idx_type       end_a;
   idx_type       sum_b;
   idx_type       end_b;
   idx_type       rd_a_idx;
   idx_type       rd_b_idx;
   logic          can_load;

   logic                     ram0_we;
   logic                     ram1_we;
   logic [ADDR_W-1:0]        ram0_waddr;
   logic signed [DATA_W-1:0] ram0_wdata;
   logic [DATA_W-1:0]        ram0_rd_a;
   logic [DATA_W-1:0]        ram0_rd_b;
   logic [DATA_W-1:0]        ram1_rd_a;
   logic [DATA_W-1:0]        ram1_rd_b;
   logic signed [DATA_W-1:0] head_a;
   logic signed [DATA_W-1:0] head_b;
   logic signed [DATA_W-1:0] merge_wdata;
   merge_step_type           step;

   // sel_ff names the ram holding the current source runs
   assign head_a = sel_ff ? $signed(ram1_rd_a) : $signed(ram0_rd_a);
   assign head_b = sel_ff ? $signed(ram1_rd_b) : $signed(ram0_rd_b);

   msort_merge u_merge (
      .pos     (pos_ff),
      .head_a  (head_a),
      .head_b  (head_b),
      .step    (step),
      .wr_data (merge_wdata)
   );

   assign cap_idx  = idx_type'(CAPACITY);
   assign req_ready = state_ff == ST_LOAD;
   assign req_fire  = req_valid && req_ready;
   assign load_wr   = req_fire && (cnt_ff < cap_idx);
   assign n_close   = load_wr ? cnt_ff + idx_type'(1) : cnt_ff;
   assign width2    = {width_ff[IDX_W-2:0], 1'b0};
   assign lo_step   = lo_ff + width2;
   assign sum_a     = lo_ff + width_ff;
   assign end_a     = (sum_a < cnt_ff) ? sum_a : cnt_ff;
   assign sum_b     = lo_step;
   assign end_b     = (sum_b < cnt_ff) ? sum_b : cnt_ff;
   assign can_load  = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      sel_in       = sel_ff;
      pos_in       = pos_ff;
      out_idx_in   = out_idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      rd_a_idx     = pos_ff.i;
      rd_b_idx     = pos_ff.j;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               cnt_in = n_close;
               if (!load_wr) begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  width_in = idx_type'(1);
                  lo_in    = '0;
                  sel_in   = 1'b0;
                  state_in = (n_close > idx_type'(1)) ? ST_PAIR : ST_OUT_START;
               end
            end
         end
         ST_PAIR: begin
            // right run starts where the left one ends; empty if clipped
            pos_in.i     = lo_ff;
            pos_in.j     = end_a;
            pos_in.k     = lo_ff;
            pos_in.a_end = end_a;
            pos_in.b_end = end_b;
            rd_a_idx     = lo_ff;
            rd_b_idx     = end_a;
            state_in     = ST_MERGE;
         end
         ST_MERGE: begin
            pos_in.i = step.i_nxt;
            pos_in.j = step.j_nxt;
            pos_in.k = step.k_nxt;
            rd_a_idx = step.i_nxt;
            rd_b_idx = step.j_nxt;
            if (step.run_done) begin
               if (lo_step < cnt_ff) begin
                  lo_in    = lo_step;
                  state_in = ST_PAIR;
               end else begin
                  lo_in    = '0;
                  width_in = width2;
                  sel_in   = !sel_ff;
                  state_in = (width2 < cnt_ff) ? ST_PAIR : ST_OUT_START;
               end
            end
         end
         ST_OUT_START: begin
            rd_a_idx   = '0;
            out_idx_in = '0;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rd_a_idx = out_idx_ff;
            if (can_load) begin
               out_valid_in = 1'b1;
               out_value_in = head_a;
               out_last_in  = (out_idx_ff + idx_type'(1)) == cnt_ff;
               out_ovf_in   = ovf_ff;
               out_idx_in   = out_idx_ff + idx_type'(1);
               rd_a_idx     = out_idx_ff + idx_type'(1);
               if ((out_idx_ff + idx_type'(1)) == cnt_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // ram0 takes loads and merge writes while sel_ff is set, ram1 merge writes while it is clear
   always_comb begin
      ram0_we    = load_wr || ((state_ff == ST_MERGE) && sel_ff);
      ram1_we    = (state_ff == ST_MERGE) && !sel_ff;
      ram0_waddr = (state_ff == ST_LOAD) ? cnt_ff[ADDR_W-1:0] : pos_ff.k[ADDR_W-1:0];
      ram0_wdata = (state_ff == ST_LOAD) ? req_value : merge_wdata;
   end

   msort_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram0 (
      .clock     (clock),
      .wr_en     (ram0_we),
      .wr_addr   (ram0_waddr),
      .wr_data   (ram0_wdata),
      .rd_addr_a (rd_a_idx[ADDR_W-1:0]),
      .rd_addr_b (rd_b_idx[ADDR_W-1:0]),
      .rd_data_a (ram0_rd_a),
      .rd_data_b (ram0_rd_b)
   );

   msort_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram1 (
      .clock     (clock),
      .wr_en     (ram1_we),
      .wr_addr   (pos_ff.k[ADDR_W-1:0]),
      .wr_data   (merge_wdata),
      .rd_addr_a (rd_a_idx[ADDR_W-1:0]),
      .rd_addr_b (rd_b_idx[ADDR_W-1:0]),
      .rd_data_a (ram1_rd_a),
      .rd_data_b (ram1_rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         width_ff     <= idx_type'(1);
         lo_ff        <= '0;
         sel_ff       <= 1'b0;
         out_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         width_ff     <= width_in;
         lo_ff        <= lo_in;
         sel_ff       <= sel_in;
         out_idx_ff   <= out_idx_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff       <= pos_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_sorted_value = out_value_ff;
   assign rsp_last_out     = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

`default_nettype wire

[src/msort_ram.sv]
// generic synchronous ram: one write port, two registered read ports
// no dependencies
`default_nettype none

module msort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

[src/msort_merge.sv]
// one step of a two-run merge: compares the run heads, picks the output
// element and advances the run pointers; depends on msort_pkg
`default_nettype none

module msort_merge (
   input  wire msort_pkg::merge_pos_type        pos,
   input  wire logic signed [msort_pkg::DATA_W-1:0] head_a,
   input  wire logic signed [msort_pkg::DATA_W-1:0] head_b,
   output msort_pkg::merge_step_type            step,
   output logic signed [msort_pkg::DATA_W-1:0]  wr_data
);

   import msort_pkg::*;

   logic a_ok;
   logic b_ok;

   always_comb begin
      a_ok = pos.i < pos.a_end;
      b_ok = pos.j < pos.b_end;
      // left run wins ties to keep the sort stable
      step.take_a   = a_ok && (!b_ok || (head_a <= head_b));
      step.i_nxt    = step.take_a ? pos.i + idx_type'(1) : pos.i;
      step.j_nxt    = step.take_a ? pos.j : pos.j + idx_type'(1);
      step.k_nxt    = pos.k + idx_type'(1);
      step.run_done = step.k_nxt == pos.b_end;
      wr_data       = step.take_a ? head_a : head_b;
   end

endmodule

`default_nettype wire

[verif/merge_sorter_top_test.sv]
// self-checking testbench for merge_sorter_top: blocks of signed values in, ascending results out
// predicts each block with its own stable sort or stored answer; checks every result field in order
// depends on msort_pkg and the merge_sorter_top rtl
`default_nettype none

module merge_sorter_top_test;
   import msort_pkg::*;

   localparam int CAP            = DEF_CAPACITY;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int TARGET_ITEMS   = 380;
   localparam int DIRECTED_COUNT = 21;
   // start the long stall once the full and overflowing blocks are through
   localparam int HOLDOFF_AT     = DIRECTED_COUNT + CAP + CAP + 1 + 10;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_in;
      logic                     has_answer;
      logic signed [DATA_W-1:0] answer;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     overflow;
   } result_type;

   // single-value blocks carry their answer; the rest go through the predictor
   localparam req_item_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{32'h80000000, 1'b1, 1'b1, 32'h80000000},
      '{32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff},
      '{32'h00000000, 1'b1, 1'b1, 32'h00000000},
      '{32'hffffffff, 1'b1, 1'b1, 32'hffffffff},
      '{32'h00000001, 1'b1, 1'b1, 32'h00000001},
      '{32'd5,        1'b0, 1'b0, 32'd0},
      '{-32'sd3,      1'b0, 1'b0, 32'd0},
      '{32'd5,        1'b0, 1'b0, 32'd0},
      '{32'h80000000, 1'b0, 1'b0, 32'd0},
      '{32'h7fffffff, 1'b0, 1'b0, 32'd0},
      '{32'hffffffff, 1'b0, 1'b0, 32'd0},
      '{32'd0,        1'b0, 1'b0, 32'd0},
      '{32'd5,        1'b1, 1'b0, 32'd0},
      '{-32'sd7,      1'b0, 1'b0, 32'd0},
      '{32'd7,        1'b1, 1'b0, 32'd0},
      '{32'd100,      1'b0, 1'b0, 32'd0},
      '{-32'sd100,    1'b1, 1'b0, 32'd0},
      '{32'd42,       1'b0, 1'b0, 32'd0},
      '{32'd42,       1'b1, 1'b0, 32'd0},
      '{32'haaaaaaaa, 1'b0, 1'b0, 32'd0},
      '{32'h55555555, 1'b1, 1'b0, 32'd0}
   };

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_value        = '0;
   logic                     req_last_in      = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_last_out;
   logic                     rsp_overflow;

   req_item_type             stim_q[$];
   result_type               sorted_q[$];
   logic signed [DATA_W-1:0] block_vals[$];
   logic                     block_overflow = 1'b0;

   req_item_type             cur_item;
   int                       next_idx       = 0;
   int                       burst_left     = 0;
   int                       gap_left       = 0;
   int                       req_accepts    = 0;
   int                       rx_cycle       = 0;
   int                       holdoff_left   = 0;
   logic                     holdoff_used   = 1'b0;
   int                       idle_cycles    = 0;
   int                       mismatches     = 0;
   int                       fail_count     = 0;

   merge_sorter_top #(
      .CAPACITY (CAP)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // store one value of the block; a closing request sorts and queues the results
   function void load_and_sort(req_item_type it);
      logic signed [DATA_W-1:0] vals[$];
      logic signed [DATA_W-1:0] key;
      int                       j;
      result_type               r;
      if (block_vals.size() < CAP)
         block_vals.push_back(it.value);
      else
         block_overflow = 1'b1;
      if (it.last_in) begin
         vals = block_vals;
         // insertion sort: strict compare keeps equal keys in arrival order
         for (int i = 1; i < vals.size(); i++) begin
            key = vals[i];
            j = i - 1;
            while (j >= 0 && vals[j] > key) begin
               vals[j+1] = vals[j];
               j--;
            end
            vals[j+1] = key;
         end
         for (int i = 0; i < vals.size(); i++) begin
            r.sorted_value = vals[i];
            r.last_out     = (i == vals.size() - 1);
            r.overflow     = block_overflow;
            sorted_q.push_back(r);
         end
         block_vals.delete();
         block_overflow = 1'b0;
      end
   endfunction

   function logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         1: return int'($urandom_range(0, 8)) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h80000000;
               1: return 32'h7fffffff;
               2: return 32'h00000000;
               default: return 32'hffffffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic add_block(int size);
      req_item_type it;
      for (int i = 0; i < size; i++) begin
         it.value      = pick_value();
         it.last_in    = (i == size - 1);
         it.has_answer = 1'b0;
         it.answer     = '0;
         stim_q.push_back(it);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (sorted_q.size() == 0) begin
         fail_count++;
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: value %0d last %0b overflow %0b",
                     rsp_sorted_value, rsp_last_out, rsp_overflow);
      end else begin
         want = sorted_q.pop_front();
         if (rsp_sorted_value !== want.sorted_value || rsp_last_out !== want.last_out ||
             rsp_overflow !== want.overflow) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                        want.sorted_value, want.last_out, want.overflow,
                        rsp_sorted_value, rsp_last_out, rsp_overflow);
         end
      end
   endtask

   // request side: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (cur_item.has_answer)
               sorted_q.push_back(result_type'{cur_item.answer, 1'b1, 1'b0});
            else
               load_and_sort(cur_item);
            req_accepts <= req_accepts + 1;
         end
         if (req_valid && !req_ready) begin
            // hold the pending request
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (next_idx < stim_q.size()) begin
            cur_item = stim_q[next_idx];
            next_idx++;
            req_valid   <= 1'b1;
            req_value   <= cur_item.value;
            req_last_in <= cur_item.last_in;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: rotating stall patterns plus one long hold-off
   always @(posedge clock) begin
      rx_cycle++;
      if (!reset && rsp_valid && rsp_ready)
         check_result();
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (!holdoff_used && req_accepts >= HOLDOFF_AT && rsp_valid) begin
         // a result is waiting and is held throughout; input stalls while the block sorts or has results left
         holdoff_used = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 89) % 4)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((rx_cycle / 5) % 3 != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < DIRECTED_COUNT; i++)
         stim_q.push_back(DIRECTED_ROWS[i]);
      // full store, then one request too many on the closing request
      add_block(CAP);
      add_block(CAP + 1);
      while (stim_q.size() < TARGET_ITEMS) begin
         case ($urandom_range(0, 99)) inside
            [0:69]:  add_block($urandom_range(1, 10));
            [70:86]: add_block($urandom_range(11, 40));
            [87:93]: add_block(CAP);
            default: add_block($urandom_range(CAP + 1, CAP + 8));
         endcase
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_accepts < stim_q.size() || sorted_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
